// ===== hw/rtl/bdq_pkg.sv =====
// shared types and codes for the bounded deque with search
`default_nettype none

package bdq_pkg;

    localparam int DEPTH_DEF     = 32;
    localparam int WORD_BITS_DEF = 32;

    localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [2:0] ACT_POP_BACK   = 3'd3;
    localparam logic [2:0] ACT_FIND       = 3'd4;
    localparam logic [2:0] ACT_LIST       = 3'd5;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_EMPTY     = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_SCAN,
        S_FIN
    } t_state;

endpackage

`default_nettype wire

// ===== hw/rtl/bdq_ram.sv =====
// ring storage: one write port, one registered read port
`default_nettype none

module bdq_ram
    import bdq_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]     i_wr_addr,
    input  wire logic [WORD_BITS-1:0]         i_wr_data,
    input  wire logic                         i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]     i_rd_addr,
    output logic      [WORD_BITS-1:0]         o_rd_data
);

    logic [WORD_BITS-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bounded_deque_with_search_top.sv =====
// bounded deque with linear search: top level with sequencer and result register
//
// input channel: i_valid / o_stall carry one beat of i_action and i_value.
// output channel: o_valid / i_stall carry result beats of o_status,
// o_position, o_word and o_last; o_last marks the final beat of each item.
// push front and push back give one beat (ok or full).
// pop front and pop back do one ram read, then give the beat
// with the removed word (or one empty beat on an empty list).
// find and list do one ram read per entry and one compare per cycle in
// the shared compare unit, unless the scan is held; then a final state.
// a match is held one step so the last beat can be flagged; find with
// no match gives one not-found beat, find or list on an empty list one
// empty beat. actions 6 and 7 are taken and give no beat.
// the block takes one item at a time; o_stall is high while an item is
// at work and while a result beat waits on a stalled receiver.
// a stalled receiver holds the scan at the next match, payload held.
// synchronous reset empties the list at once; ram contents are not cleared.
`default_nettype none

module bounded_deque_with_search_top
    import bdq_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic        [2:0]  i_action,
    input  wire logic signed [31:0] i_value,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic             [1:0]  o_status,
    output logic             [5:0]  o_position,
    output logic signed      [31:0] o_word,
    output logic                    o_last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_state r_state, n_state;
    logic [AW-1:0] r_front, n_front;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_slot, n_slot;
    logic [AW-1:0] r_idx, n_idx;
    logic          r_list, n_list;
    logic [WORD_BITS-1:0] r_key, n_key;
    logic          r_hold_v, n_hold_v;
    logic [5:0]    r_hold_pos, n_hold_pos;
    logic [31:0]   r_hold_word, n_hold_word;
    logic          r_o_valid, n_o_valid;
    logic [1:0]    r_o_status;
    logic [5:0]    r_o_pos;
    logic [31:0]   r_o_word;
    logic          r_o_last;

    logic          load_o;
    logic [1:0]    lo_status;
    logic [5:0]    lo_pos;
    logic [31:0]   lo_word;
    logic          lo_last;

    logic                 ram_wr_en, ram_rd_en;
    logic [AW-1:0]        ram_wr_addr, ram_rd_addr;
    logic [WORD_BITS-1:0] ram_rd_data;

    logic                 out_free, accept, full, empty, hit, last_idx;
    logic [63:0]          v64, rd64, pos64;
    logic [WORD_BITS-1:0] new_word;
    logic [31:0]          rd_word;
    logic [AW:0]          sum_back, sum_last, idx_nxt;
    logic [AW-1:0]        slot_back, slot_last, front_dec, front_inc, slot_inc;
    logic [5:0]           pos6;

    assign out_free = !r_o_valid || !i_stall;
    assign o_stall  = !((r_state == S_IDLE) && out_free);
    assign accept   = i_valid && !o_stall;
    assign full     = (r_count == CW'(DEPTH));
    assign empty    = (r_count == '0);

    assign v64      = {32'd0, i_value};
    assign new_word = v64[WORD_BITS-1:0];
    assign rd64     = 64'(ram_rd_data);
    assign rd_word  = rd64[31:0];

    assign sum_back  = (AW+1)'(r_front) + (AW+1)'(r_count);
    assign sum_last  = sum_back - (AW+1)'(1);
    assign slot_back = (sum_back >= (AW+1)'(DEPTH)) ? AW'(sum_back - (AW+1)'(DEPTH))
                                                    : sum_back[AW-1:0];
    assign slot_last = (sum_last >= (AW+1)'(DEPTH)) ? AW'(sum_last - (AW+1)'(DEPTH))
                                                    : sum_last[AW-1:0];
    assign front_dec = (r_front == '0) ? AW'(DEPTH - 1) : r_front - AW'(1);
    assign front_inc = (r_front == AW'(DEPTH - 1)) ? '0 : r_front + AW'(1);
    assign slot_inc  = (r_slot == AW'(DEPTH - 1)) ? '0 : r_slot + AW'(1);

    assign idx_nxt  = (AW+1)'(r_idx) + (AW+1)'(1);
    assign pos64    = 64'(idx_nxt);
    assign pos6     = pos64[5:0];
    assign last_idx = (idx_nxt == (AW+1)'(r_count));

    // shared compare unit
    assign hit = r_list || (ram_rd_data == r_key);

    always_comb begin
        n_state     = r_state;
        n_front     = r_front;
        n_count     = r_count;
        n_slot      = r_slot;
        n_idx       = r_idx;
        n_list      = r_list;
        n_key       = r_key;
        n_hold_v    = r_hold_v;
        n_hold_pos  = r_hold_pos;
        n_hold_word = r_hold_word;
        ram_wr_en   = 1'b0;
        ram_wr_addr = slot_back;
        ram_rd_en   = 1'b0;
        ram_rd_addr = r_slot;
        load_o      = 1'b0;
        lo_status   = STAT_OK;
        lo_pos      = '0;
        lo_word     = '0;
        lo_last     = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_action)
                        ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                            load_o = 1'b1;
                            if (full) begin
                                lo_status = STAT_FULL;
                            end else begin
                                ram_wr_en = 1'b1;
                                if (i_action == ACT_PUSH_FRONT) begin
                                    ram_wr_addr = front_dec;
                                    n_front     = front_dec;
                                end
                                n_count = r_count + CW'(1);
                            end
                        end
                        ACT_POP_FRONT, ACT_POP_BACK: begin
                            if (empty) begin
                                load_o    = 1'b1;
                                lo_status = STAT_EMPTY;
                            end else begin
                                ram_rd_en = 1'b1;
                                if (i_action == ACT_POP_FRONT) begin
                                    ram_rd_addr = r_front;
                                    n_front     = front_inc;
                                end else begin
                                    ram_rd_addr = slot_last;
                                end
                                n_count = r_count - CW'(1);
                                n_state = S_POP;
                            end
                        end
                        ACT_FIND, ACT_LIST: begin
                            if (empty) begin
                                load_o    = 1'b1;
                                lo_status = STAT_EMPTY;
                            end else begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = r_front;
                                n_slot      = front_inc;
                                n_idx       = '0;
                                n_key       = new_word;
                                n_list      = (i_action == ACT_LIST);
                                n_hold_v    = 1'b0;
                                n_state     = S_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_POP: begin
                if (out_free) begin
                    load_o  = 1'b1;
                    lo_word = rd_word;
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                if (!(hit && r_hold_v && !out_free)) begin
                    if (hit) begin
                        if (r_hold_v) begin
                            load_o  = 1'b1;
                            lo_pos  = r_hold_pos;
                            lo_word = r_hold_word;
                            lo_last = 1'b0;
                        end
                        n_hold_v    = 1'b1;
                        n_hold_pos  = pos6;
                        n_hold_word = rd_word;
                    end
                    if (last_idx) begin
                        n_state = S_FIN;
                    end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = r_slot;
                        n_slot      = slot_inc;
                        n_idx       = idx_nxt[AW-1:0];
                    end
                end
            end
            S_FIN: begin
                if (out_free) begin
                    load_o = 1'b1;
                    if (r_hold_v) begin
                        lo_pos  = r_hold_pos;
                        lo_word = r_hold_word;
                    end else begin
                        lo_status = STAT_NOT_FOUND;
                    end
                    n_hold_v = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_o_valid = load_o ? 1'b1 : (out_free ? 1'b0 : r_o_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_front   <= '0;
            r_count   <= '0;
            r_hold_v  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_front   <= n_front;
            r_count   <= n_count;
            r_hold_v  <= n_hold_v;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot      <= n_slot;
        r_idx       <= n_idx;
        r_list      <= n_list;
        r_key       <= n_key;
        r_hold_pos  <= n_hold_pos;
        r_hold_word <= n_hold_word;
        if (load_o) begin
            r_o_status <= lo_status;
            r_o_pos    <= lo_pos;
            r_o_word   <= lo_word;
            r_o_last   <= lo_last;
        end
    end

    bdq_ram #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (new_word),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign o_valid    = r_o_valid;
    assign o_status   = r_o_status;
    assign o_position = r_o_pos;
    assign o_word     = r_o_word;
    assign o_last     = r_o_last;

endmodule

`default_nettype wire

// ===== hw/rtl/bdq_chk.sv =====
// port-level checks for the bounded deque with search, bound to the top level
`default_nettype none

module bdq_chk
    import bdq_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_stall,
    input wire logic               o_valid,
    input wire logic               i_stall,
    input wire logic        [1:0]  o_status,
    input wire logic        [5:0]  o_position,
    input wire logic signed [31:0] o_word,
    input wire logic               o_last
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_position)
            && $stable(o_word) && $stable(o_last))
        else $error("stalled result beat changed");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat right after reset");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != STAT_OK) |-> o_last && (o_position == '0) && (o_word == '0))
        else $error("error beat not a lone final beat");

    a_pos_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_position != '0) |-> (o_status == STAT_OK))
        else $error("position on a non-ok beat");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |-> o_stall)
        else $error("input taken while result stalled");

endmodule

bind bounded_deque_with_search_top bdq_chk u_bdq_chk (.*);

`default_nettype wire

// ===== sim/bdq_checker.sv =====
// result predictor and scoreboard for the bounded deque with search
`default_nettype none

module bdq_checker
    import bdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic [2:0]  i_action,
    input  wire logic [31:0] i_value,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [1:0]  i_status,
    input  wire logic [5:0]  i_position,
    input  wire logic [31:0] i_word,
    input  wire logic        i_last,
    output int               o_mismatches,
    output int               o_pending,
    output int               o_results
);

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  position;
        logic [31:0] word;
        logic        last;
    } t_beat;

    logic [31:0] ring [DEPTH];
    int unsigned front_idx = 0;
    int unsigned fill      = 0;
    t_beat       awaited_q [$];
    int          mismatches = 0;
    int          results    = 0;

    function automatic t_beat beat_of(input logic [1:0] st, input logic [5:0] pos,
                                      input logic [31:0] w, input logic lst);
        t_beat b;
        b.status   = st;
        b.position = pos;
        b.word     = w;
        b.last     = lst;
        return b;
    endfunction

    task automatic apply_action(input logic [2:0] act, input logic [31:0] val);
        int unsigned k;
        logic [31:0] w;
        t_beat       held;
        logic        have_held;
        have_held = 1'b0;
        held      = '0;
        case (act)
            ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                if (fill >= DEPTH) begin
                    awaited_q.push_back(beat_of(STAT_FULL, '0, '0, 1'b1));
                end else begin
                    if (act == ACT_PUSH_FRONT) begin
                        front_idx = (front_idx + DEPTH - 1) % DEPTH;
                        ring[front_idx] = val;
                    end else begin
                        ring[(front_idx + fill) % DEPTH] = val;
                    end
                    fill++;
                    awaited_q.push_back(beat_of(STAT_OK, '0, '0, 1'b1));
                end
            end
            ACT_POP_FRONT, ACT_POP_BACK: begin
                if (fill == 0) begin
                    awaited_q.push_back(beat_of(STAT_EMPTY, '0, '0, 1'b1));
                end else begin
                    if (act == ACT_POP_FRONT) begin
                        w = ring[front_idx];
                        front_idx = (front_idx + 1) % DEPTH;
                    end else begin
                        w = ring[(front_idx + fill - 1) % DEPTH];
                    end
                    fill--;
                    awaited_q.push_back(beat_of(STAT_OK, '0, w, 1'b1));
                end
            end
            ACT_FIND, ACT_LIST: begin
                if (fill == 0) begin
                    awaited_q.push_back(beat_of(STAT_EMPTY, '0, '0, 1'b1));
                end else begin
                    for (k = 0; k < fill; k++) begin
                        w = ring[(front_idx + k) % DEPTH];
                        if (act == ACT_LIST || w == val) begin
                            if (have_held) awaited_q.push_back(held);
                            held      = beat_of(STAT_OK, 6'(k + 1), w, 1'b0);
                            have_held = 1'b1;
                        end
                    end
                    if (!have_held) begin
                        awaited_q.push_back(beat_of(STAT_NOT_FOUND, '0, '0, 1'b1));
                    end else begin
                        held.last = 1'b1;
                        awaited_q.push_back(held);
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic compare_beat();
        t_beat got;
        t_beat want;
        got = beat_of(i_status, i_position, i_word, i_last);
        results++;
        if (awaited_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("result beat %0d unexpected: status %0d position %0d word %h last %b",
                         results, got.status, got.position, got.word, got.last);
        end else begin
            want = awaited_q.pop_front();
            if (got.status !== want.status || got.position !== want.position ||
                got.word !== want.word || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result beat %0d: expected status %0d position %0d word %h ",
                             results, want.status, want.position, want.word,
                             "last %b, got status %0d position %0d word %h last %b",
                             want.last, got.status, got.position, got.word, got.last);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            front_idx = 0;
            fill      = 0;
            awaited_q.delete();
        end else begin
            if (i_in_valid && !i_in_stall) apply_action(i_action, i_value);
            if (i_out_valid && !i_out_stall) compare_beat();
        end
        o_pending    <= awaited_q.size();
        o_mismatches <= mismatches;
        o_results    <= results;
    end

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// testbench top: stimulus, output stalls and verdict for the bounded deque with search
`default_nettype none

module tb_top;
    import bdq_pkg::*;

    localparam logic [2:0] ACT_SPARE_6   = 3'd6;
    localparam logic [2:0] ACT_SPARE_7   = 3'd7;
    localparam int         RANDOM_ITEMS  = 220;
    localparam int         BURST_LEN     = 34;
    localparam int         HOLD_CYCLES   = 300;
    localparam int         DRAIN_CYCLES  = 40;
    localparam int         TIMEOUT_UNITS = 5_000_000;

    logic               i_clk    = 1'b0;
    logic               i_rst_n  = 1'b0;
    logic               i_valid  = 1'b0;
    logic        [2:0]  i_action = ACT_PUSH_FRONT;
    logic signed [31:0] i_value  = '0;
    logic               i_stall  = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic        [1:0]  o_status;
    logic        [5:0]  o_position;
    logic signed [31:0] o_word;
    logic               o_last;

    int          tx_idle_pct  = 17;
    int          rx_idle_pct  = 72;
    logic        hold_go      = 1'b0;
    int          holds_done   = 0;
    int          items_sent   = 0;
    int          random_items = 0;
    logic [31:0] key_pool [8];
    int          mismatches;
    int          pending;
    int          results;

    bounded_deque_with_search_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_action   (i_action),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_status   (o_status),
        .o_position (o_position),
        .o_word     (o_word),
        .o_last     (o_last)
    );

    bdq_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_action     (i_action),
        .i_value      (i_value),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_status     (o_status),
        .i_position   (o_position),
        .i_word       (o_word),
        .i_last       (o_last),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_results    (results)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #TIMEOUT_UNITS;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // output side stall, with an occasional long hold-off
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_go) begin
                hold_go = 1'b0;
                holds_done++;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
            end else begin
                i_stall <= ($urandom_range(0, 99) < rx_idle_pct);
            end
        end
    end

    task automatic offer_item(input logic [2:0] act, input logic [31:0] val);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_action <= act;
        i_value  <= val;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
    endtask

    function automatic logic [31:0] pick_value();
        if ($urandom_range(0, 99) < 55) return key_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    task automatic offer_random_op();
        int          r;
        logic [2:0]  act;
        r = $urandom_range(0, 99);
        if (r < 24)      act = ACT_PUSH_FRONT;
        else if (r < 48) act = ACT_PUSH_BACK;
        else if (r < 60) act = ACT_POP_FRONT;
        else if (r < 72) act = ACT_POP_BACK;
        else if (r < 86) act = ACT_FIND;
        else if (r < 96) act = ACT_LIST;
        else if (r < 98) act = ACT_SPARE_6;
        else             act = ACT_SPARE_7;
        offer_item(act, pick_value());
        if (act != ACT_SPARE_6 && act != ACT_SPARE_7) random_items++;
    endtask

    initial begin
        int   seq;
        int   sel;
        int   phase;
        logic late_hold;
        seq       = 0;
        late_hold = 1'b0;
        for (int i = 0; i < 8; i++) key_pool[i] = $urandom;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty list corners
        offer_item(ACT_POP_FRONT, 32'h0);
        offer_item(ACT_POP_BACK, 32'h0);
        offer_item(ACT_FIND, 32'h0);
        offer_item(ACT_LIST, 32'h0);
        // extremes at both ends, duplicate key
        offer_item(ACT_PUSH_FRONT, 32'h7fff_ffff);
        offer_item(ACT_PUSH_BACK, 32'h8000_0000);
        offer_item(ACT_PUSH_FRONT, 32'hffff_ffff);
        offer_item(ACT_PUSH_BACK, 32'h0);
        offer_item(ACT_PUSH_BACK, 32'hffff_ffff);
        offer_item(ACT_LIST, 32'h0);
        offer_item(ACT_FIND, 32'hffff_ffff);
        offer_item(ACT_FIND, 32'h8000_0000);
        offer_item(ACT_FIND, 32'h1234_5678);
        offer_item(ACT_SPARE_6, 32'hffff_ffff);
        offer_item(ACT_SPARE_7, 32'h0);
        offer_item(ACT_POP_FRONT, 32'h0);
        offer_item(ACT_POP_BACK, 32'h0);
        offer_item(ACT_FIND, 32'h7fff_ffff);
        offer_item(ACT_POP_FRONT, 32'h0);
        offer_item(ACT_POP_BACK, 32'h0);
        offer_item(ACT_POP_BACK, 32'h0);
        offer_item(ACT_POP_BACK, 32'h0);

        while (random_items < RANDOM_ITEMS) begin
            phase = random_items * 3 / RANDOM_ITEMS;
            case (phase)
                0: begin
                    tx_idle_pct = 17;
                    rx_idle_pct = 72;
                end
                1: begin
                    tx_idle_pct = 72;
                    rx_idle_pct = 17;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                    if (!late_hold) begin
                        late_hold = 1'b1;
                        hold_go   = 1'b1;
                    end
                end
            endcase
            sel = $urandom_range(0, 9);
            if (seq == 0 || sel == 0) begin
                // fill past full, then walk the whole list
                repeat (BURST_LEN) begin
                    offer_item($urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT,
                               pick_value());
                    random_items++;
                end
                if (seq == 0) hold_go = 1'b1;
                offer_item(ACT_LIST, pick_value());
                offer_item(ACT_FIND, key_pool[$urandom_range(0, 7)]);
                random_items += 2;
            end else if (sel == 1) begin
                repeat (BURST_LEN) begin
                    offer_item($urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT,
                               pick_value());
                    random_items++;
                end
            end else begin
                repeat (8) offer_random_op();
            end
            seq++;
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d input beats (%0d random) and %0d result beats",
                 items_sent, random_items, results);
        $display("empty/full corners, fill and drain bursts, three idle mixes, %0d hold-offs",
                 holds_done);
        if (mismatches == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
hw/rtl/bdq_pkg.sv
hw/rtl/bdq_ram.sv
hw/rtl/bounded_deque_with_search_top.sv
hw/rtl/bdq_chk.sv
sim/bdq_checker.sv
sim/tb_top.sv
